// File: hw/rtl/ptg_pkg.sv
// Shared types and constants for the proximity touch gesture block.
// No dependencies; imported by the top level, both checkers and the testbench.
package ptg_pkg;

    // Field widths
    localparam int unsigned PROX_W  = 10;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DUR_W   = 16;
    localparam int unsigned EVENT_W = 3;
    localparam int unsigned SPEED_W = 17;
    localparam int unsigned QUO_W   = 16;

    // Stream payload widths, padded to whole bytes
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 24;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Fixed levels
    localparam logic [PROX_W-1:0]  SAT_LEVEL = 10'd1023;
    localparam logic [TIME_W-1:0]  FAST_MS   = 32'd100;
    localparam logic [SPEED_W-1:0] ONE_Q16   = 17'd65536;

    // Register reset values
    localparam logic [PROX_W-1:0] MIN_THRESH_RST = 10'd300;
    localparam logic [PROX_W-1:0] MAX_THRESH_RST = 10'd900;
    localparam logic [DUR_W-1:0]  MAX_DUR_RST    = 16'd1000;
    localparam logic [DUR_W-1:0]  LOCKOUT_RST    = 16'd3000;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MIN_THRESH = 2'd0,
        REG_MAX_THRESH = 2'd1,
        REG_MAX_DUR    = 2'd2,
        REG_LOCKOUT    = 2'd3
    } cfg_reg_t;

    // Event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_IDLE       = 3'd0,
        EV_APPROACH   = 3'd1,
        EV_DONE       = 3'd2,
        EV_HELD       = 3'd3,
        EV_INCOMPLETE = 3'd4,
        EV_RELEASED   = 3'd5,
        EV_CLOSE      = 3'd6,
        EV_LOCKED     = 3'd7
    } event_t;

endpackage

// File: hw/rtl/proximity_touch_gesture_fsm.sv
// Top level of the proximity touch gesture block: gesture state machine,
// configuration registers and a bit-serial speed divider. Uses ptg_pkg.
//
// One input transaction (proximity, now_ms) gives one output transaction
// (event_code, speed). Most samples produce their result in the output
// register in the cycle after acceptance. A touch completed from the approaching
// mode with an elapsed time strictly between 100 ms and max_duration_ms runs
// the restoring divider, which retires one quotient bit per cycle; its
// result enters the output register with the last bit. A new sample is accepted once
// the divider is idle and the output register is empty or being drained in
// that cycle. Configuration writes are taken in any cycle and must only be
// issued while no sample is in flight.
module proximity_touch_gesture_fsm (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tdata: [9:0] proximity, [41:10] now_ms, [47:42] zero
    input  logic [ptg_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: [2:0] event_code, [19:3] speed, [23:20] zero
    output logic [ptg_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_wr_en,
    input  logic [ptg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ptg_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import ptg_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_APPROACH,
        MODE_HELD,
        MODE_RELEASE,
        MODE_CLOSE
    } mode_t;

    typedef enum logic {
        CTL_READY,
        CTL_DIVIDE
    } ctl_t;

    // Configuration registers
    logic [PROX_W-1:0] min_thresh_reg, min_thresh_next;
    logic [PROX_W-1:0] max_thresh_reg, max_thresh_next;
    logic [DUR_W-1:0]  max_dur_reg, max_dur_next;
    logic [DUR_W-1:0]  lockout_reg, lockout_next;

    // Gesture state
    mode_t             mode_reg, mode_next;
    logic [TIME_W-1:0] approach_start_reg, approach_start_next;
    logic [TIME_W-1:0] saturate_start_reg, saturate_start_next;

    // Control and output register
    ctl_t               ctl_reg, ctl_next;
    logic               m_valid_reg, m_valid_next;
    event_t             event_reg, event_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;

    // Divider
    logic [QUO_W-1:0] div_rem_reg, div_rem_next;
    logic [QUO_W-1:0] div_quo_reg, div_quo_next;
    logic [QUO_W-1:0] div_span_reg, div_span_next;
    logic [3:0]       div_cnt_reg, div_cnt_next;

    logic [PROX_W-1:0] prox;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] sat_elapsed;
    logic              is_fast;
    logic              is_slow;
    logic              accept;
    logic [QUO_W:0]    rem_dbl;
    logic [QUO_W:0]    rem_sub;
    logic              quo_bit;
    logic [QUO_W-1:0]  quo_new;

    assign prox   = s_tdata[PROX_W-1:0];
    assign now_ms = s_tdata[PROX_W +: TIME_W];

    assign s_tready = (ctl_reg == CTL_READY) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - EVENT_W - SPEED_W){1'b0}}, speed_reg, event_reg};

    // Elapsed times, modulo 2^32
    assign elapsed     = now_ms - approach_start_reg;
    assign sat_elapsed = now_ms - saturate_start_reg;
    assign is_fast     = elapsed <= FAST_MS;
    assign is_slow     = elapsed >= {{(TIME_W - DUR_W){1'b0}}, max_dur_reg};

    // One restoring division step: double, trial subtract, keep or restore
    assign rem_dbl = {div_rem_reg, 1'b0};
    assign rem_sub = rem_dbl - {1'b0, div_span_reg};
    assign quo_bit = !rem_sub[QUO_W];
    assign quo_new = {div_quo_reg[QUO_W-2:0], quo_bit};

    always_comb begin
        min_thresh_next     = min_thresh_reg;
        max_thresh_next     = max_thresh_reg;
        max_dur_next        = max_dur_reg;
        lockout_next        = lockout_reg;
        mode_next           = mode_reg;
        approach_start_next = approach_start_reg;
        saturate_start_next = saturate_start_reg;
        ctl_next            = ctl_reg;
        m_valid_next        = m_valid_reg;
        event_next          = event_reg;
        speed_next          = speed_reg;
        div_rem_next        = div_rem_reg;
        div_quo_next        = div_quo_reg;
        div_span_next       = div_span_reg;
        div_cnt_next        = div_cnt_reg;

        // Register writes
        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_MIN_THRESH: min_thresh_next = cfg_wr_data[PROX_W-1:0];
                REG_MAX_THRESH: max_thresh_next = cfg_wr_data[PROX_W-1:0];
                REG_MAX_DUR:    max_dur_next    = cfg_wr_data;
                REG_LOCKOUT:    lockout_next    = cfg_wr_data;
                default: ;
            endcase
        end

        // Drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (ctl_reg)
            CTL_READY: begin
                if (accept) begin
                    m_valid_next = 1'b1;
                    event_next   = EV_IDLE;
                    speed_next   = '0;
                    unique case (mode_reg)
                        MODE_IDLE: begin
                            if (prox >= SAT_LEVEL) begin
                                mode_next           = MODE_CLOSE;
                                saturate_start_next = now_ms;
                                event_next          = EV_CLOSE;
                            end else if (prox >= max_thresh_reg) begin
                                mode_next  = MODE_HELD;
                                event_next = EV_DONE;
                                speed_next = ONE_Q16;
                            end else if (prox > min_thresh_reg) begin
                                mode_next           = MODE_APPROACH;
                                approach_start_next = now_ms;
                                event_next          = EV_APPROACH;
                            end
                        end
                        MODE_APPROACH: begin
                            if (prox >= max_thresh_reg) begin
                                mode_next  = MODE_HELD;
                                event_next = EV_DONE;
                                if (is_fast) begin
                                    speed_next = ONE_Q16;
                                end else if (is_slow) begin
                                    speed_next = '0;
                                end else begin
                                    // Hold the result until the divider finishes
                                    m_valid_next  = 1'b0;
                                    ctl_next      = CTL_DIVIDE;
                                    div_rem_next  = elapsed[QUO_W-1:0] - FAST_MS[QUO_W-1:0];
                                    div_span_next = max_dur_reg - FAST_MS[QUO_W-1:0];
                                    div_quo_next  = '0;
                                    div_cnt_next  = '0;
                                end
                            end else if (prox <= min_thresh_reg) begin
                                mode_next  = MODE_IDLE;
                                event_next = EV_INCOMPLETE;
                            end else begin
                                event_next = EV_APPROACH;
                            end
                        end
                        MODE_HELD: begin
                            if (prox < max_thresh_reg) begin
                                mode_next = MODE_RELEASE;
                            end else begin
                                event_next = EV_HELD;
                            end
                        end
                        MODE_RELEASE: begin
                            if (prox >= max_thresh_reg) begin
                                mode_next  = MODE_HELD;
                                event_next = EV_DONE;
                                speed_next = ONE_Q16;
                            end else if (prox <= min_thresh_reg) begin
                                mode_next  = MODE_IDLE;
                                event_next = EV_RELEASED;
                            end
                        end
                        MODE_CLOSE: begin
                            if (prox >= SAT_LEVEL) begin
                                if (sat_elapsed >= {{(TIME_W - DUR_W){1'b0}}, lockout_reg}) begin
                                    mode_next  = MODE_IDLE;
                                    event_next = EV_LOCKED;
                                end else begin
                                    event_next = EV_CLOSE;
                                end
                            end else if (prox < max_thresh_reg) begin
                                mode_next  = MODE_IDLE;
                                event_next = EV_RELEASED;
                            end else begin
                                mode_next  = MODE_HELD;
                                event_next = EV_HELD;
                            end
                        end
                        default: mode_next = MODE_IDLE;
                    endcase
                end
            end
            CTL_DIVIDE: begin
                // Advance one quotient bit per cycle
                div_rem_next = quo_bit ? rem_sub[QUO_W-1:0] : rem_dbl[QUO_W-1:0];
                div_quo_next = quo_new;
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'(QUO_W - 1)) begin
                    ctl_next     = CTL_READY;
                    m_valid_next = 1'b1;
                    event_next   = EV_DONE;
                    speed_next   = ONE_Q16 - {1'b0, quo_new};
                end
            end
            default: ctl_next = CTL_READY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_thresh_reg     <= MIN_THRESH_RST;
            max_thresh_reg     <= MAX_THRESH_RST;
            max_dur_reg        <= MAX_DUR_RST;
            lockout_reg        <= LOCKOUT_RST;
            mode_reg           <= MODE_IDLE;
            approach_start_reg <= '0;
            saturate_start_reg <= '0;
            ctl_reg            <= CTL_READY;
            m_valid_reg        <= 1'b0;
        end else begin
            min_thresh_reg     <= min_thresh_next;
            max_thresh_reg     <= max_thresh_next;
            max_dur_reg        <= max_dur_next;
            lockout_reg        <= lockout_next;
            mode_reg           <= mode_next;
            approach_start_reg <= approach_start_next;
            saturate_start_reg <= saturate_start_next;
            ctl_reg            <= ctl_next;
            m_valid_reg        <= m_valid_next;
        end
        event_reg    <= event_next;
        speed_reg    <= speed_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_span_reg <= div_span_next;
        div_cnt_reg  <= div_cnt_next;
    end

endmodule

// File: hw/rtl/ptg_checker.sv
// Port-level checks for the proximity touch gesture block, bound to the top.
// Uses ptg_pkg; sees only the ports of proximity_touch_gesture_fsm.
module ptg_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [ptg_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready
);
    import ptg_pkg::*;

    // Output register is empty after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result pending right after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Speed is zero unless a touch completed
    a_speed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[EVENT_W-1:0] != EV_DONE) |-> m_tdata[EVENT_W +: SPEED_W] == '0)
        else $error("nonzero speed on a non-completion event");

    // Speed never exceeds 1.0
    a_speed_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[EVENT_W +: SPEED_W] <= ONE_Q16)
        else $error("speed above 1.0");

    // A sample is taken only when its result has room
    a_accept_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !m_tvalid || m_tready)
        else $error("sample accepted while output register full");

endmodule

bind proximity_touch_gesture_fsm ptg_checker u_ptg_checker (.*);

// File: verif/proximity_touch_gesture_fsm_checker.sv
// Checker for the proximity touch gesture block: follows register writes,
// predicts the event and speed of every sample and compares them with the
// output stream. Depends on ptg_pkg.
module proximity_touch_gesture_fsm_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tdata: [9:0] proximity, [41:10] now_ms, [47:42] zero
    input  logic [ptg_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // tdata: [2:0] event_code, [19:3] speed, [23:20] zero
    input  logic [ptg_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wr_en,
    input  logic [ptg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ptg_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output int unsigned                    fail_count,
    output int unsigned                    pending_count
);
    import ptg_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_APPROACH = 3'd1,
        MODE_HELD     = 3'd2,
        MODE_RELEASE  = 3'd3,
        MODE_CLOSE    = 3'd4
    } gesture_mode_t;

    typedef struct packed {
        event_t             code;
        logic [SPEED_W-1:0] speed;
    } touch_result_t;

    // Shadow registers and gesture state
    logic [PROX_W-1:0] min_thresh;
    logic [PROX_W-1:0] max_thresh;
    logic [DUR_W-1:0]  max_dur;
    logic [DUR_W-1:0]  lockout;
    gesture_mode_t     mode;
    logic [TIME_W-1:0] approach_t0;
    logic [TIME_W-1:0] saturate_t0;

    touch_result_t     expected_touches[$];
    int unsigned       errors;
    int unsigned       results;

    // Q16 speed from the approach time: full inside 100 ms, zero at the
    // configured end of the ramp, linear fall in between
    function automatic logic [SPEED_W-1:0] approach_speed(input logic [TIME_W-1:0] elapsed);
        logic [63:0] frac;
        if (elapsed <= FAST_MS)
            return ONE_Q16;
        if (elapsed >= {16'd0, max_dur})
            return '0;
        frac = ({32'd0, elapsed - FAST_MS} << 16) / ({48'd0, max_dur} - 64'd100);
        return ONE_Q16 - frac[SPEED_W-1:0];
    endfunction

    // Advance the gesture state by one sample and return its event and speed
    function automatic touch_result_t predict_touch(input logic [PROX_W-1:0] prox,
                                                    input logic [TIME_W-1:0] now);
        touch_result_t     r;
        logic [TIME_W-1:0] sat_time;
        r.code  = EV_IDLE;
        r.speed = '0;
        case (mode)
            MODE_IDLE: begin
                if (prox >= SAT_LEVEL) begin
                    mode        = MODE_CLOSE;
                    saturate_t0 = now;
                    r.code      = EV_CLOSE;
                end else if (prox >= max_thresh) begin
                    mode    = MODE_HELD;
                    r.code  = EV_DONE;
                    r.speed = ONE_Q16;
                end else if (prox > min_thresh) begin
                    mode        = MODE_APPROACH;
                    approach_t0 = now;
                    r.code      = EV_APPROACH;
                end
            end
            MODE_APPROACH: begin
                if (prox >= max_thresh) begin
                    mode    = MODE_HELD;
                    r.code  = EV_DONE;
                    r.speed = approach_speed(now - approach_t0);
                end else if (prox <= min_thresh) begin
                    mode   = MODE_IDLE;
                    r.code = EV_INCOMPLETE;
                end else begin
                    r.code = EV_APPROACH;
                end
            end
            MODE_HELD: begin
                if (prox < max_thresh)
                    mode = MODE_RELEASE;
                else
                    r.code = EV_HELD;
            end
            MODE_RELEASE: begin
                if (prox >= max_thresh) begin
                    mode    = MODE_HELD;
                    r.code  = EV_DONE;
                    r.speed = ONE_Q16;
                end else if (prox <= min_thresh) begin
                    mode   = MODE_IDLE;
                    r.code = EV_RELEASED;
                end
            end
            MODE_CLOSE: begin
                sat_time = now - saturate_t0;
                if (prox >= SAT_LEVEL) begin
                    if (sat_time >= {16'd0, lockout}) begin
                        mode   = MODE_IDLE;
                        r.code = EV_LOCKED;
                    end else begin
                        r.code = EV_CLOSE;
                    end
                end else if (prox < max_thresh) begin
                    mode   = MODE_IDLE;
                    r.code = EV_RELEASED;
                end else begin
                    mode   = MODE_HELD;
                    r.code = EV_HELD;
                end
            end
            // unused mode codes fall back to idle
            default: mode = MODE_IDLE;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        touch_result_t got;
        touch_result_t want;
        if (!aresetn) begin
            min_thresh  = MIN_THRESH_RST;
            max_thresh  = MAX_THRESH_RST;
            max_dur     = MAX_DUR_RST;
            lockout     = LOCKOUT_RST;
            mode        = MODE_IDLE;
            approach_t0 = '0;
            saturate_t0 = '0;
            errors      = 0;
            results     = 0;
            expected_touches.delete();
        end else begin
            // Track register writes
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_MIN_THRESH: min_thresh = cfg_wr_data[PROX_W-1:0];
                    REG_MAX_THRESH: max_thresh = cfg_wr_data[PROX_W-1:0];
                    REG_MAX_DUR:    max_dur    = cfg_wr_data[DUR_W-1:0];
                    REG_LOCKOUT:    lockout    = cfg_wr_data[DUR_W-1:0];
                    default: ;
                endcase
            end

            // Compare each output transaction with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.code  = event_t'(m_tdata[EVENT_W-1:0]);
                got.speed = m_tdata[EVENT_W +: SPEED_W];
                if (expected_touches.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ptg check: result %0d (event %0d speed %0d) with none pending",
                                 results, got.code, got.speed);
                end else begin
                    want = expected_touches.pop_front();
                    if (got != want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"ptg check: result %0d expected event %0d speed %0d, ",
                                      "got event %0d speed %0d"},
                                     results, want.code, want.speed, got.code, got.speed);
                    end
                end
                results++;
            end

            // Predict each accepted input transaction
            if (s_tvalid && s_tready)
                expected_touches.push_back(predict_touch(s_tdata[PROX_W-1:0],
                                                         s_tdata[PROX_W +: TIME_W]));
        end
        fail_count    <= errors;
        pending_count <= expected_touches.size();
    end

endmodule

// File: verif/proximity_touch_gesture_fsm_test.sv
// Testbench top for the proximity touch gesture block: clock, reset, register
// setup and sample stimulus. Depends on ptg_pkg, the block and its checker.
module proximity_touch_gesture_fsm_test;
    import ptg_pkg::*;

    typedef enum logic [1:0] {
        Z_LOW  = 2'd0,
        Z_MID  = 2'd1,
        Z_HIGH = 2'd2,
        Z_SAT  = 2'd3
    } level_zone_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata     = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    int unsigned           fail_count;
    int unsigned           pending_count;

    // Stimulus copy of the registers, used only to aim samples at the zones and times
    logic [PROX_W-1:0]     cur_min     = MIN_THRESH_RST;
    logic [PROX_W-1:0]     cur_max     = MAX_THRESH_RST;
    logic [DUR_W-1:0]      cur_dur     = MAX_DUR_RST;
    logic [DUR_W-1:0]      cur_lock    = LOCKOUT_RST;
    logic [TIME_W-1:0]     ms_clock    = '0;
    bit                    gaps_on     = 1'b1;
    logic                  rx_hold_req = 1'b0;
    int unsigned           sent        = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    proximity_touch_gesture_fsm i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    proximity_touch_gesture_fsm_checker i_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Offer one sample, idling at random first while gaps are on, and hold it until accepted
    task automatic send_sample(input logic [PROX_W-1:0] prox, input logic [TIME_W-1:0] t);
        while (gaps_on && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - PROX_W - TIME_W){1'b0}}, t, prox};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent++;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending_count != 0);
        repeat (24) @(posedge aclk);
    endtask

    task automatic write_config(input logic [15:0] lo, input logic [15:0] hi,
                                input logic [15:0] dur, input logic [15:0] lock);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_MIN_THRESH;
        cfg_wr_data <= lo;
        @(posedge aclk);
        cfg_addr    <= REG_MAX_THRESH;
        cfg_wr_data <= hi;
        @(posedge aclk);
        cfg_addr    <= REG_MAX_DUR;
        cfg_wr_data <= dur;
        @(posedge aclk);
        cfg_addr    <= REG_LOCKOUT;
        cfg_wr_data <= lock;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_min  = lo[PROX_W-1:0];
        cur_max  = hi[PROX_W-1:0];
        cur_dur  = dur;
        cur_lock = lock;
    endtask

    function automatic logic [TIME_W-1:0] tick(input int unsigned lo, input int unsigned hi);
        ms_clock = ms_clock + $urandom_range(hi, lo);
        return ms_clock;
    endfunction

    // Pick a proximity in a zone of the current thresholds; any reading
    // when the zone is empty
    function automatic logic [PROX_W-1:0] pick_level(input level_zone_t z);
        int unsigned lo;
        int unsigned hi;
        lo = cur_min;
        hi = cur_max;
        case (z)
            Z_LOW:  return PROX_W'($urandom_range(lo, 0));
            Z_MID:  if (hi > lo + 1) return PROX_W'($urandom_range(hi - 1, lo + 1));
            Z_HIGH: if (hi <= 1022) return PROX_W'($urandom_range(1022, hi));
            Z_SAT:  return SAT_LEVEL;
            default: ;
        endcase
        return PROX_W'($urandom_range(1023, 0));
    endfunction

    // Approach time: fast, on the ramp, around its end, or anything
    function automatic logic [TIME_W-1:0] pick_elapsed();
        case ($urandom_range(5))
            0:       return $urandom_range(100, 0);
            1:       return 32'd101;
            2:       return 32'(cur_dur) + $urandom_range(2, 0) - 1;
            3:       return $urandom();
            default: return $urandom_range(32'(cur_dur) + 5, 101);
        endcase
    endfunction

    // Full touch: rest, approach, complete (or give up), hold, release
    task automatic approach_run();
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] e;
        int unsigned       steps;
        send_sample(pick_level(Z_LOW), tick(1, 50));
        t0 = tick(1, 50);
        send_sample(pick_level(Z_MID), t0);
        e     = pick_elapsed();
        steps = $urandom_range(3, 0);
        for (int unsigned k = 1; k <= steps; k++)
            send_sample(pick_level(Z_MID), t0 + e / (steps + 1) * k);
        ms_clock = t0 + e;
        if ($urandom_range(7) == 0) begin
            send_sample(pick_level(Z_LOW), ms_clock);
        end else begin
            send_sample(pick_level(Z_HIGH), ms_clock);
            repeat ($urandom_range(3, 0)) send_sample(pick_level(Z_HIGH), tick(1, 40));
            if ($urandom_range(1) == 1) begin
                send_sample(pick_level(Z_MID), tick(1, 40));
                if ($urandom_range(1) == 1)
                    send_sample(pick_level(Z_HIGH), tick(1, 40));
            end
            send_sample(pick_level(Z_LOW), tick(1, 40));
        end
    endtask

    // Saturation: hold full scale around the lockout time, then leave
    task automatic saturate_run();
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] d;
        t0 = tick(1, 60);
        send_sample(SAT_LEVEL, t0);
        case ($urandom_range(4))
            0:       d = $urandom_range(32'(cur_lock), 0);
            1:       d = 32'(cur_lock) - 1;
            2:       d = 32'(cur_lock);
            3:       d = $urandom();
            default: d = 32'(cur_lock) + $urandom_range(50, 1);
        endcase
        if ($urandom_range(1) == 1)
            send_sample(SAT_LEVEL, t0 + d / 2);
        send_sample(SAT_LEVEL, t0 + d);
        ms_clock = t0 + d;
        case ($urandom_range(2))
            0:       send_sample(pick_level(Z_HIGH), tick(1, 20));
            1:       send_sample(pick_level(Z_LOW), tick(1, 20));
            default: ;
        endcase
        send_sample(pick_level(Z_LOW), tick(1, 20));
    endtask

    task automatic random_phase(input int unsigned n_items);
        int unsigned stop_at;
        stop_at = sent + n_items;
        while (sent < stop_at) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: approach_run();
                5, 6:          saturate_run();
                default: begin
                    // noise: any reading at any time
                    if ($urandom_range(3) == 0)
                        send_sample(PROX_W'($urandom()), $urandom());
                    else
                        send_sample(PROX_W'($urandom()), tick(0, 300));
                end
            endcase
        end
        settle();
    endtask

    task automatic random_config_phase();
        int unsigned lo;
        int unsigned hi;
        logic [15:0] dur;
        logic [15:0] lock;
        lo   = $urandom_range(700, 0);
        hi   = ($urandom_range(4) == 0) ? $urandom_range(1023, 0) : $urandom_range(1023, lo + 1);
        dur  = ($urandom_range(4) == 0) ? 16'($urandom()) : 16'($urandom_range(3000, 101));
        lock = ($urandom_range(4) == 0) ? 16'($urandom()) : 16'($urandom_range(5000, 0));
        write_config({6'($urandom()), 10'(lo)}, {6'($urandom()), 10'(hi)}, dur, lock);
        ms_clock = $urandom();
        random_phase(110);
    endtask

    // Receiver: random ready (always ready with gaps off), with one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req <= 1'b0;
                m_tready    <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            m_tready <= !gaps_on || ($urandom_range(99) >= 31);
        end
    end

    initial begin
        #4_000_000;
        $display("proximity_touch_gesture_fsm: mismatch");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed samples under the reset register values
        send_sample(10'd0, 32'd0);
        send_sample(SAT_LEVEL, 32'd10);             // too close
        send_sample(SAT_LEVEL, 32'd3009);           // one short of lockout
        send_sample(SAT_LEVEL, 32'd3010);           // lockout exactly at the limit
        send_sample(10'd950, 32'd3020);             // completed straight from idle
        send_sample(10'd950, 32'd3030);             // held
        send_sample(10'd500, 32'd3040);             // releasing
        send_sample(10'd900, 32'd3050);             // completed again while releasing
        send_sample(10'd899, 32'd3060);
        send_sample(10'd300, 32'd3070);             // released at the lower threshold
        send_sample(10'd301, 32'd4000);             // approach just above threshold
        send_sample(10'd600, 32'd4050);
        send_sample(10'd300, 32'd4060);             // incomplete approach
        send_sample(10'd301, 32'd5000);
        send_sample(10'd900, 32'd5100);             // 100 ms: full speed
        send_sample(10'd0, 32'd5110);
        send_sample(10'd0, 32'd5120);
        send_sample(10'd400, 32'd6000);
        send_sample(10'd1022, 32'd6101);            // first step of the ramp
        send_sample(10'd0, 32'd6110);
        send_sample(10'd0, 32'd6120);
        send_sample(SAT_LEVEL, 32'hFFFF_FFF0);
        send_sample(10'd950, 32'hFFFF_FFFF);        // leave too close into held
        send_sample(10'd0, 32'h0000_0005);
        send_sample(10'd0, 32'h0000_0006);
        send_sample(10'd400, 32'hFFFF_FFC0);
        send_sample(10'd900, 32'h0000_0010);        // elapsed time wraps past zero
        settle();

        // Widest thresholds and longest times, junk above the threshold bits
        write_config(16'hFC00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        ms_clock = 32'hFFFF_F000;
        random_phase(110);

        // Crossed thresholds, shortest ramp, instant lockout, no idling
        gaps_on = 1'b0;
        write_config(16'h03FF, 16'h0000, 16'd101, 16'd0);
        random_phase(110);
        gaps_on = 1'b1;

        // Ramp shorter than 100 ms; hold off the receiver to fill the block
        write_config(16'd100, 16'd800, 16'd50, 16'd10);
        rx_hold_req <= 1'b1;
        random_phase(55);
        random_phase(55);

        write_config(16'd0, 16'd0, 16'd0, 16'd1);
        random_phase(60);

        repeat (5) random_config_phase();

        repeat (30) @(posedge aclk);
        if (fail_count == 0)
            $display("proximity_touch_gesture_fsm: match");
        else
            $display("proximity_touch_gesture_fsm: mismatch");
        $finish;
    end

endmodule
